FILE: hw/rtl/hsir_pkg.sv
// Package for the humidity sensor I2C reader: register indexes, widths, command table.
// No dependencies.
`default_nettype none
package hsir_pkg;
  localparam int unsigned GapW  = 16;
  localparam int unsigned WaitW = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] RegResetGap = 2'd0;
  localparam logic [CfgIdxW-1:0] RegConvWait = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRepeatGap = 2'd2;

  localparam logic [GapW-1:0]  ResetGapDefault = 16'd250;
  localparam logic [WaitW-1:0] ConvWaitDefault = 20'd20000;
  localparam logic [WaitW-1:0] RepeatGapDefault = 20'd0;

  // Command byte for transaction group t, byte index i
  function automatic logic [7:0] cmd_byte(input logic [1:0] t, input logic [2:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (t)
      2'd0: b = (i == 3'd0) ? 8'h70 : (i == 3'd1) ? 8'hBA : 8'h00;
      2'd1: b = (i == 3'd0) ? 8'h70 : (i == 3'd1) ? 8'hE1 : (i == 3'd2) ? 8'h08 : 8'h00;
      2'd2: b = (i == 3'd0) ? 8'h70 : (i == 3'd1) ? 8'hAC : (i == 3'd2) ? 8'h33 : 8'h00;
      2'd3: b = (i == 3'd0) ? 8'h71 : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] cmd_count(input logic [1:0] t);
    logic [2:0] c;
    unique case (t)
      2'd0: c = 3'd2;
      2'd1: c = 3'd4;
      2'd2: c = 3'd4;
      default: c = 3'd7;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/hsir_convert.sv
// Registered conversion of raw sensor fields to tenths.
// Depends on hsir_pkg.
`default_nettype none
module hsir_convert (
  input  wire logic        clk_i,
  input  wire logic [19:0] hum_raw_i,
  input  wire logic [19:0] temp_raw_i,
  output logic      [9:0]  hum_o,
  output logic      [10:0] temp_o
);
  import hsir_pkg::*;
  logic [29:0] hprod;
  logic [30:0] tprod;
  logic [9:0]  hum_q;
  logic [10:0] temp_q;
  // Scale: raw*1000 and raw*2000, keep bits from 20 up
  assign hprod = 30'(hum_raw_i) * 30'd1000;
  assign tprod = 31'(temp_raw_i) * 31'd2000;
  always_ff @(posedge clk_i) begin
    hum_q  <= hprod[29:20];
    temp_q <= tprod[30:20];
  end
  assign hum_o  = hum_q;
  assign temp_o = temp_q;
endmodule
`default_nettype wire

FILE: hw/rtl/humidity_sensor_i2c_reader_top.sv
// Humidity sensor I2C reader: one bus phase per accepted item, one result per item.
// The result is registered when the item is accepted; one item per cycle while the
// output is not stalled, set by the single-pass phase logic between input and result
// registers. Conversion products are registered from the shift register in advance.
// Reset (asynchronous, active low) clears sequence, counters and readings, and loads
// the config defaults.
// Depends on hsir_pkg and hsir_convert.
`default_nettype none
module humidity_sensor_i2c_reader_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          sda_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               scl_out_o,
  output logic                               sda_drive_low_o,
  output logic [9:0]                         humidity_tenths_o,
  output logic signed [11:0]                 temperature_tenths_o,
  output logic                               reading_valid_o,
  output logic                               status_bad_o,
  output logic                               ack_ok_o,
  output logic                               busy_res_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hsir_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hsir_pkg::CfgDataW-1:0] cfg_data_i
);
  import hsir_pkg::*;

  logic [GapW-1:0]  gap_q;
  logic [WaitW-1:0] conv_q, rep_q;
  logic [4:0]  step_q, step_d;
  logic [4:0]  bp_q, bp_d;
  logic [2:0]  bi_q, bi_d;
  logic [47:0] sh_q, sh_d;
  logic [WaitW-1:0] wc_q, wc_d;
  logic [9:0]  hum_q, hum_d;
  logic [10:0] temp_q, temp_d;
  logic        ack_q, ack_d;
  logic [9:0]  hum_cv;
  logic [10:0] temp_cv;
  logic        ovalid_q;
  logic        scl, low, busy, good, bad;
  logic        fire;
  logic [4:0]  s0, s1;
  logic [WaitW-1:0] lim;
  logic [1:0]  t, kind;
  logic        reading;
  logic [7:0]  b;
  logic [2:0]  bi_inc;
  logic [4:0]  sm1;

  assign fire        = in_valid_i && !in_stall_o;
  assign in_stall_o  = ovalid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  hsir_convert u_conv (
    .clk_i     (clk_i),
    .hum_raw_i (sh_q[39:20]),
    .temp_raw_i(sh_q[19:0]),
    .hum_o     (hum_cv),
    .temp_o    (temp_cv)
  );

  function automatic logic [WaitW-1:0] limit_of(input logic [1:0] tt,
      input logic [GapW-1:0] g, input logic [WaitW-1:0] c, input logic [WaitW-1:0] r);
    logic [WaitW-1:0] v;
    unique case (tt)
      2'd2: v = c;
      2'd3: v = r;
      default: v = WaitW'(g);
    endcase
    return v;
  endfunction

  // Phase logic: resolve finished waits (at most one skip chain), then act
  always_comb begin
    s0 = (step_q > 5'd16) ? 5'd0 : step_q;
    wc_d = wc_q;
    s1 = s0;
    // A finished wait advances; the next step is never a wait, so one skip suffices
    if (s0 != 5'd0 && s0[1:0] == 2'd0) begin
      lim = limit_of(2'(s0[4:2] - 3'd1), gap_q, conv_q, rep_q);
      if (wc_q >= lim) begin
        wc_d = '0;
        s1 = (s0 == 5'd16) ? 5'd0 : s0 + 5'd1;
      end
    end else begin
      lim = '0;
    end
    step_d = s1; bp_d = bp_q; bi_d = bi_q; sh_d = sh_q; ack_d = ack_q;
    hum_d = hum_q; temp_d = temp_q;
    scl = 1'b1; low = 1'b0; busy = 1'b0; good = 1'b0; bad = 1'b0;
    sm1 = s1 - 5'd1;
    t = sm1[3:2]; kind = sm1[1:0];
    reading = (t == 2'd3) && (bi_q != 3'd0);
    b = cmd_byte(t, bi_q);
    bi_inc = bi_q + 3'd1;
    if (s1 == 5'd0) begin
      step_d = 5'd1; bp_d = '0; bi_d = '0;
    end else if (s1[1:0] == 2'd0) begin
      wc_d = wc_d + 1'b1;
    end else begin
      busy = 1'b1;
      unique case (kind)
        2'd0: begin
          if (bp_q == 5'd0) bp_d = 5'd1;
          else begin
            low = 1'b1; bp_d = '0; bi_d = '0;
            if (t == 2'd3) sh_d = '0;
            step_d = s1 + 5'd1;
          end
        end
        2'd1: begin
          scl = bp_q[0];
          if (bp_q < 5'd16) begin
            if (reading) begin
              if (scl) sh_d = {sh_q[46:0], sda_in_i};
            end else begin
              low = !b[3'd7 - bp_q[3:1]];
            end
          end else if (reading) begin
            low = (bi_q < 3'd6);
          end else if (scl) begin
            ack_d = !sda_in_i;
          end
          if (bp_q >= 5'd17) begin
            bp_d = '0;
            bi_d = bi_inc;
            if (bi_inc >= cmd_count(t)) begin
              bi_d = '0; step_d = s1 + 5'd1;
            end
          end else begin
            bp_d = bp_q + 5'd1;
          end
        end
        default: begin
          if (bp_q == 5'd0) begin
            scl = 1'b0; low = 1'b1; bp_d = 5'd1;
          end else if (bp_q == 5'd1) begin
            low = 1'b1; bp_d = 5'd2;
          end else begin
            bp_d = '0; wc_d = '0; step_d = s1 + 5'd1;
            if (t == 2'd3) begin
              if ((sh_q[47:40] & 8'h68) == 8'h08) begin
                good = 1'b1; hum_d = hum_cv; temp_d = temp_cv;
              end else bad = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Hold state, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= ResetGapDefault; conv_q <= ConvWaitDefault; rep_q <= RepeatGapDefault;
      step_q <= '0; bp_q <= '0; bi_q <= '0; sh_q <= '0; wc_q <= '0;
      hum_q <= '0; temp_q <= '0; ack_q <= 1'b0; ovalid_q <= 1'b0;
      scl_out_o <= 1'b1; sda_drive_low_o <= 1'b0; reading_valid_o <= 1'b0;
      status_bad_o <= 1'b0; busy_res_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegResetGap:  gap_q  <= cfg_data_i[GapW-1:0];
          RegConvWait:  conv_q <= cfg_data_i;
          RegRepeatGap: rep_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        step_q <= step_d; bp_q <= bp_d; bi_q <= bi_d; sh_q <= sh_d; wc_q <= wc_d;
        hum_q <= hum_d; temp_q <= temp_d; ack_q <= ack_d;
        scl_out_o <= scl; sda_drive_low_o <= low; reading_valid_o <= good;
        status_bad_o <= bad; busy_res_o <= busy;
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign humidity_tenths_o = hum_q;
  assign temperature_tenths_o = $signed({1'b0, temp_q}) - 12'sd500;
  assign ack_ok_o = ack_q;

`ifndef ASSERT_OFF
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(reading_valid_o && status_bad_o)) else $error("valid and bad together");
  a_pulse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reading_valid_o || status_bad_o) |-> busy_res_o)
    else $error("pulse outside stop");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= 5'd16) else $error("step out of range");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o) |=> $stable(step_q)) else $error("state moved while stalled");
`endif
endmodule
`default_nettype wire

FILE: test/humidity_sensor_i2c_reader_top_test.sv
// Self-checking testbench for humidity_sensor_i2c_reader_top: drives bus phases with SDA
// levels, predicts every phase result and checks each result field against the prediction.
// Depends on hsir_pkg and the reader RTL.
`timescale 1ns / 1ps

module humidity_sensor_i2c_reader_top_test;
  import hsir_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned RxHoldCycles = 300;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [7:0] StatusMask = 8'h68;
  localparam logic [7:0] StatusGood = 8'h08;
  localparam logic [4:0] StepIdle = 5'd0;
  localparam logic [4:0] StepLast = 5'd16;
  localparam logic [4:0] StepReadStart = 5'd13;
  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindBytes = 2'd1;
  localparam logic [1:0] GroupRead = 2'd3;

  typedef struct packed {
    logic              scl;
    logic              low;
    logic [9:0]        hum;
    logic signed [11:0] temp;
    logic              good;
    logic              bad;
    logic              ack;
    logic              busy;
  } phase_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic sda_in_i = 1'b1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic scl_out_o, sda_drive_low_o, reading_valid_o, status_bad_o, ack_ok_o, busy_res_o;
  logic [9:0] humidity_tenths_o;
  logic signed [11:0] temperature_tenths_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  humidity_sensor_i2c_reader_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sda_in_i, .out_valid_o, .out_stall_i,
    .scl_out_o, .sda_drive_low_o, .humidity_tenths_o, .temperature_tenths_o,
    .reading_valid_o, .status_bad_o, .ack_ok_o, .busy_res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sequencer model state and its copy of the registers
  logic [15:0] gap_phases;
  logic [19:0] conv_phases;
  logic [19:0] repeat_phases;
  logic [4:0]  seq_step;
  logic [4:0]  bit_ph;
  logic [2:0]  byte_idx;
  logic [47:0] rx_frame;
  logic [19:0] wait_cnt;
  logic [9:0]  hum_q;
  logic [10:0] temp_q;
  logic        ack_q;
  logic [47:0] sensor_frame;

  phase_result_t phase_q[$];
  int unsigned errors = 0;
  int unsigned reads_done = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;
  bit rx_hold_req = 1'b0;
  int unsigned rx_stall_left = 0;

  function automatic logic [19:0] wait_limit(input logic [1:0] grp);
    if (grp == 2'd2) return conv_phases;
    if (grp == GroupRead) return repeat_phases;
    return {4'd0, gap_phases};
  endfunction

  function automatic void reset_sequencer();
    gap_phases = ResetGapDefault;
    conv_phases = ConvWaitDefault;
    repeat_phases = RepeatGapDefault;
    seq_step = StepIdle;
    bit_ph = '0;
    byte_idx = '0;
    rx_frame = '0;
    wait_cnt = '0;
    hum_q = '0;
    temp_q = '0;
    ack_q = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [19:0] val);
    case (idx)
      RegResetGap:  gap_phases = val[15:0];
      RegConvWait:  conv_phases = val;
      RegRepeatGap: repeat_phases = val;
      default: ;
    endcase
  endfunction

  // Command bytes of each bus group, written out here
  function automatic logic [7:0] cmd_table(input logic [1:0] grp, input logic [2:0] i);
    case ({grp, i})
      {2'd0, 3'd0}, {2'd1, 3'd0}, {2'd2, 3'd0}: return 8'h70;
      {2'd0, 3'd1}: return 8'hBA;
      {2'd1, 3'd1}: return 8'hE1;
      {2'd1, 3'd2}: return 8'h08;
      {2'd2, 3'd1}: return 8'hAC;
      {2'd2, 3'd2}: return 8'h33;
      {2'd3, 3'd0}: return 8'h71;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] group_bytes(input logic [1:0] grp);
    case (grp)
      2'd0: return 3'd2;
      2'd1, 2'd2: return 3'd4;
      default: return 3'd7;
    endcase
  endfunction

  // Advance the sequencer by one bus phase and return the levels it drives
  function automatic phase_result_t predict_phase(input logic sda);
    phase_result_t r;
    logic [1:0] grp, kind;
    logic [4:0] bp;
    logic [4:0] step_m1;
    logic [7:0] cmd, status;
    logic reading, done;
    longint unsigned hraw, traw;
    r = '0;
    r.scl = 1'b1;
    done = 1'b0;
    // skip waits that have run out
    while (!done) begin
      if (seq_step > StepLast) seq_step = StepIdle;
      done = 1'b1;
      if (seq_step != StepIdle && seq_step[1:0] == 2'd0) begin
        grp = seq_step[3:2] - 2'd1;
        if (seq_step == StepLast) grp = GroupRead;
        if (wait_cnt >= wait_limit(grp)) begin
          wait_cnt = '0;
          seq_step = (grp == GroupRead) ? StepIdle : seq_step + 5'd1;
          done = 1'b0;
        end
      end
    end
    if (seq_step == StepIdle) begin
      seq_step = 5'd1;
      bit_ph = '0;
      byte_idx = '0;
    end else if (seq_step[1:0] == 2'd0) begin
      wait_cnt = wait_cnt + 20'd1;
    end else begin
      step_m1 = seq_step - 5'd1;
      grp = step_m1[3:2];
      kind = step_m1[1:0];
      bp = bit_ph;
      r.busy = 1'b1;
      if (kind == KindStart) begin
        if (bp == 5'd0) begin
          bit_ph = 5'd1;
        end else begin
          r.low = 1'b1;
          bit_ph = '0;
          byte_idx = '0;
          if (grp == GroupRead) rx_frame = '0;
          seq_step = seq_step + 5'd1;
        end
      end else if (kind == KindBytes) begin
        reading = (grp == GroupRead) && (byte_idx >= 3'd1);
        r.scl = bp[0];
        if (bp < 5'd16) begin
          if (reading) begin
            if (r.scl) rx_frame = {rx_frame[46:0], sda};
          end else begin
            cmd = cmd_table(grp, byte_idx);
            r.low = ~cmd[7 - (bp >> 1)];
          end
        end else if (reading) begin
          r.low = (byte_idx < 3'd6);
        end else if (r.scl) begin
          ack_q = ~sda;
        end
        if (bp >= 5'd17) begin
          bit_ph = '0;
          byte_idx = byte_idx + 3'd1;
          if (byte_idx >= group_bytes(grp)) begin
            byte_idx = '0;
            seq_step = seq_step + 5'd1;
          end
        end else begin
          bit_ph = bp + 5'd1;
        end
      end else begin
        if (bp == 5'd0) begin
          r.scl = 1'b0;
          r.low = 1'b1;
          bit_ph = 5'd1;
        end else if (bp == 5'd1) begin
          r.low = 1'b1;
          bit_ph = 5'd2;
        end else begin
          bit_ph = '0;
          wait_cnt = '0;
          seq_step = seq_step + 5'd1;
          if (grp == GroupRead) begin
            reads_done++;
            status = rx_frame[47:40];
            if ((status & StatusMask) == StatusGood) begin
              hraw = rx_frame[39:20];
              traw = rx_frame[19:0];
              hum_q = 10'((hraw * 1000) >> 20);
              temp_q = 11'((traw * 2000) >> 20);
              r.good = 1'b1;
            end else begin
              r.bad = 1'b1;
            end
          end
        end
      end
    end
    r.hum = hum_q;
    r.temp = $signed({1'b0, temp_q}) - 12'sd500;
    r.ack = ack_q;
    return r;
  endfunction

  function automatic logic [19:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // SDA level the sensor would return now: read frame bits, mostly ACKs, some noise
  function automatic logic sensor_sda();
    logic [7:0] status;
    int pos;
    if (seq_step == StepReadStart) begin
      status = 8'($urandom);
      if ($urandom_range(0, 3) != 0) status = (status & ~StatusMask) | StatusGood;
      sensor_frame = {status, pick_raw(), pick_raw()};
    end
    if ($urandom_range(0, 19) == 0) return 1'($urandom);
    if (seq_step == StepReadStart + 5'd1 && byte_idx >= 3'd1 && bit_ph < 5'd16) begin
      pos = 47 - ((int'(byte_idx) - 1) * 8 + int'(bit_ph >> 1));
      return sensor_frame[pos];
    end
    if (seq_step[1:0] == 2'd2 && bit_ph >= 5'd16) return ($urandom_range(0, 9) == 0);
    return 1'($urandom);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one bus phase and record the expected levels once it is taken
  task automatic send_phase(input logic sda);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    sda_in_i = sda;
    do @(posedge clk_i); while (in_stall_o);
    phase_q.push_back(predict_phase(sda));
  endtask

  task automatic send_sensor_phases(input int unsigned n);
    repeat (n) send_phase(sensor_sda());
  endtask

  // Drop valid and wait until every expected transaction has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (phase_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: random stalls, with one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req <= 1'b0;
      rx_stall_left <= RxHoldCycles;
      out_stall_i <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (calm || $urandom_range(0, 99) < 75) begin
      out_stall_i <= 1'b0;
    end else begin
      rx_stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    phase_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (phase_q.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        errors++;
      end else begin
        e = phase_q.pop_front();
        check_field("scl_out", e.scl, scl_out_o);
        check_field("sda_drive_low", e.low, sda_drive_low_o);
        check_field("humidity_tenths", e.hum, humidity_tenths_o);
        check_field("temperature_tenths", e.temp, temperature_tenths_o);
        check_field("reading_valid", e.good, reading_valid_o);
        check_field("status_bad", e.bad, status_bad_o);
        check_field("ack_ok", e.ack, ack_ok_o);
        check_field("busy_res", e.busy, busy_res_o);
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d transactions outstanding", $time, phase_q.size());
      $display("** humidity_sensor_i2c_reader_top: FAILED **");
      $finish;
    end
  end

  // Opening phases with reset values: idle, start, first address byte, both SDA levels
  task automatic test_after_reset();
    for (int k = 0; k < 22; k++) send_phase(k[0]);
    drain();
  endtask

  // Out-of-range index, over-wide values and the largest waits
  task automatic test_reg_extremes();
    write_reg(RegUnused, 20'hFFFFF);
    write_reg(RegResetGap, 20'hFFFFF);
    write_reg(RegConvWait, 20'hFFFFF);
    write_reg(RegRepeatGap, 20'hFFFFF);
    send_sensor_phases(300);
    drain();
  endtask

  // Every wait skipped: back-to-back sequences
  task automatic test_zero_waits();
    write_reg(RegResetGap, '0);
    write_reg(RegConvWait, '0);
    write_reg(RegRepeatGap, '0);
    send_sensor_phases(700);
    drain();
  endtask

  // Hold the receiver off while phases are offered, then pause for a full drain
  task automatic test_backpressure();
    rx_hold_req = 1'b1;
    calm = 1'b1;
    send_sensor_phases(80);
    calm = 1'b0;
    drain();
  endtask

  // Random short waits, mostly well-formed read frames
  task automatic test_random_cycles();
    int unsigned sent;
    sent = 0;
    while (sent < 600) begin
      write_reg(RegResetGap,
                ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 6)));
      write_reg(RegConvWait,
                ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 12)));
      write_reg(RegRepeatGap,
                ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 6)));
      calm = ($urandom_range(0, 3) == 0);
      send_sensor_phases(300);
      sent += 300;
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    reset_sequencer();
    sensor_frame = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_after_reset();
    test_reg_extremes();
    test_zero_waits();
    test_backpressure();
    test_random_cycles();
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && phase_q.size() == 0) begin
      $display("** humidity_sensor_i2c_reader_top: PASSED **");
    end else begin
      $display("** humidity_sensor_i2c_reader_top: FAILED **");
    end
    $finish;
  end

endmodule
